FILE: hdl/pps_pkg.sv
package pps_pkg;

	localparam int MAX_PROCESSES_DEF = 16;
	localparam int IN_DATA_W         = 40;
	localparam int OUT_DATA_W        = 104;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_REPORT
	} state_t;

	// load word, arrival in the lowest bits
	typedef struct packed {
		logic [7:0]  priority_value;
		logic [15:0] burst_time;
		logic [15:0] arrival_time;
	} load_t;

	// one row of the process table
	typedef struct packed {
		logic [15:0] remaining;
		logic [7:0]  priority_value;
		logic [15:0] burst_time;
		logic [15:0] arrival_time;
	} entry_t;

	// result word, running_index in the lowest bits
	typedef struct packed {
		logic        all_done;
		logic [31:0] waiting;
		logic [31:0] turnaround;
		logic [31:0] completion_time;
		logic        finished;
		logic        idle;
		logic [3:0]  running_index;
	} result_t;

endpackage

FILE: hdl/pps_table.sv
module pps_table import pps_pkg::*; #(
	parameter int DEPTH = MAX_PROCESSES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  entry_t                   wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output entry_t                   rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/pps_ctrl.sv
module pps_ctrl import pps_pkg::*; #(
	parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  op_t                              in_op,
	input  load_t                            in_load,
	output logic                             res_valid,
	input  logic                             res_ready,
	output result_t                          res,
	output logic                             mem_we,
	output logic [$clog2(MAX_PROCESSES)-1:0] mem_waddr,
	output entry_t                           mem_wdata,
	output logic                             mem_re,
	output logic [$clog2(MAX_PROCESSES)-1:0] mem_raddr,
	input  entry_t                           mem_rdata
);

	localparam int IDX_W = $clog2(MAX_PROCESSES);
	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         fin_cnt_q;
	logic [CNT_W-1:0]         issue_q;
	logic [31:0]              time_q;
	logic [MAX_PROCESSES-1:0] done_q;
	logic                     vld_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     found_q;
	logic                     fin_q;
	entry_t                   best_q;
	logic [IDX_W-1:0]         pick_q;
	logic [31:0]              tat_q;

	logic        load_ok;
	logic        eligible;
	logic        better;
	logic [15:0] rem_dec;
	entry_t      upd_entry;

	assign load_ok  = (count_q < CNT_W'(MAX_PROCESSES)) && (in_load.burst_time != 16'd0);
	assign eligible = vld_s1 && ({16'd0, mem_rdata.arrival_time} <= time_q)
		&& !done_q[idx_s1] && (mem_rdata.remaining != 16'd0);
	assign better   = !found_q || (mem_rdata.priority_value < best_q.priority_value);
	assign rem_dec  = best_q.remaining - 16'd1;
	assign upd_entry = {rem_dec, best_q.priority_value, best_q.burst_time,
		best_q.arrival_time};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = {in_load.burst_time, in_load};
		mem_re    = 1'b0;
		mem_raddr = issue_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_TICK) begin
						state_d = ST_SCAN;
					end else if (load_ok) begin
						mem_we = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (issue_q < count_q) begin
					mem_re = 1'b1;
				end else if (!vld_s1) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (found_q) begin
					mem_we    = 1'b1;
					mem_waddr = pick_q;
					mem_wdata = upd_entry;
				end
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			fin_cnt_q <= '0;
			issue_q   <= '0;
			time_q    <= '0;
			done_q    <= '0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			fin_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_op == OP_LOAD && load_ok) begin
						count_q                      <= count_q + CNT_W'(1);
						done_q[count_q[IDX_W-1:0]] <= 1'b0;
					end
					issue_q <= '0;
					found_q <= 1'b0;
					vld_s1  <= 1'b0;
				end
				ST_SCAN: begin
					vld_s1 <= mem_re;
					if (mem_re) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (eligible && better) begin
						found_q <= 1'b1;
					end
				end
				ST_UPDATE: begin
					time_q <= time_q + 32'd1;
					fin_q  <= found_q && (rem_dec == 16'd0);
					if (found_q && rem_dec == 16'd0) begin
						done_q[pick_q] <= 1'b1;
						fin_cnt_q      <= fin_cnt_q + CNT_W'(1);
					end
				end
				ST_REPORT: ;
				default: ;
			endcase
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			idx_s1 <= issue_q[IDX_W-1:0];
			if (eligible && better) begin
				best_q <= mem_rdata;
				pick_q <= idx_s1;
			end
		end
		if (state_q == ST_UPDATE) begin
			// time + 1 - arrival
			tat_q <= time_q + {16'hFFFF, ~best_q.arrival_time} + 32'd2;
		end
	end

	always_comb begin
		res.running_index   = found_q ? 4'(pick_q) : 4'd0;
		res.idle            = !found_q;
		res.finished        = fin_q;
		res.completion_time = time_q;
		res.turnaround      = fin_q ? tat_q : 32'd0;
		res.waiting         = fin_q ? (tat_q - {16'd0, best_q.burst_time}) : 32'd0;
		res.all_done        = (fin_cnt_q == count_q);
	end

endmodule

FILE: hdl/preemptive_priority_scheduler.sv
// Channel  Dir  Handshake         Payload
// s        in   s_tvalid/tready   tuser: operation; tdata: arrival, burst, priority
// m        out  m_tvalid/tready   tdata: index, idle, finished, times, all_done
//
// A load word is accepted in idle and its table row is written straight away,
// unless the table is full or the burst is zero. A tick word runs through
// scan, update and report steps: the scan reads one table row per cycle
// through the single read port of the table memory.
// Reset (arst_n low) empties the table, zeroes time and counters.
// A finished result sits in the output register; the next word is taken
// while it waits, and a tick only stalls in its report step if the
// register is still full.
module preemptive_priority_scheduler import pps_pkg::*; #(
	parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [15:0] arrival_time, [31:16] burst_time, [39:32] priority_value
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [0] operation
	input  logic [0:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [3:0] running_index, [4] idle, [5] finished, [37:6] completion_time,
	// [69:38] turnaround, [101:70] waiting, [102] all_done, [103] zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(MAX_PROCESSES);

	// controller to table memory
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;

	// result handoff
	logic    res_valid;
	logic    res_ready;
	result_t res;

	// output register
	logic    out_vld_q;
	result_t out_q;

	pps_table #(
		.DEPTH (MAX_PROCESSES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pps_ctrl #(
		.MAX_PROCESSES (MAX_PROCESSES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op_t'(s_tuser[0])),
		.in_load   (load_t'(s_tdata)),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// slot is free when empty or being drained this cycle
	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_q};

endmodule
